@@ src/srf_pkg.sv @@
// Shared package for the shift/rotate unit with flags.
// Holds operation and size codes, request/result structs and the
// count-modulo helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srf_pkg;

   localparam logic [2:0] KIND_ASR  = 3'd0;
   localparam logic [2:0] KIND_ASL  = 3'd1;
   localparam logic [2:0] KIND_LSR  = 3'd2;
   localparam logic [2:0] KIND_LSL  = 3'd3;
   localparam logic [2:0] KIND_ROXR = 3'd4;
   localparam logic [2:0] KIND_ROXL = 3'd5;
   localparam logic [2:0] KIND_ROR  = 3'd6;
   localparam logic [2:0] KIND_ROL  = 3'd7;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   localparam logic [5:0] ROX_MOD_BYTE = 6'd9;
   localparam logic [5:0] ROX_MOD_WORD = 6'd17;
   localparam logic [5:0] ROX_MOD_LONG = 6'd33;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  size;
      logic [5:0]  count;
      logic [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic [3:0]  flags;
      logic        extend_out;
   } rsp_type;

   // count modulo (operand width + 1): every multiple is compared in parallel
   function automatic logic [5:0] srf_rox_mod(input logic [1:0] size, input logic [5:0] count);
      logic [8:0] modulus;
      logic [8:0] step;
      logic [8:0] base;
      case (size)
         SIZE_BYTE: modulus = {3'b0, ROX_MOD_BYTE};
         SIZE_WORD: modulus = {3'b0, ROX_MOD_WORD};
         default:   modulus = {3'b0, ROX_MOD_LONG};
      endcase
      base = 9'd0;
      for (int k = 1; k < 8; k++) begin
         step = 9'(k) * modulus;
         if ({3'b0, count} >= step) begin
            base = step;
         end
      end
      return 6'({3'b0, count} - base);
   endfunction

endpackage

`default_nettype wire

@@ src/shift_rotate_unit_with_flags_unit.sv @@
// Top level of the shift/rotate unit with flags: request register, result
// register and the X flag register around srf_core. Depends on srf_pkg.
//
//   channel | ports                                        | direction
//   req     | req_valid req_stall req_kind/size/count/operand | in
//   rsp     | rsp_valid rsp_stall rsp_result/flags/extend_out | out
//
// One request per cycle sustained while rsp_stall is low.
// The request register feeds the shifter, whose output loads the result register.
// X is written as a request moves into the result register, so the next request sees it.
// Synchronous active-high reset clears valids and X to zero.
// rsp_stall holds the result register; req_stall rises only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module shift_rotate_unit_with_flags_unit import srf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_size,
   input  logic [5:0]  req_count,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result,
   output logic [3:0]  rsp_flags,
   output logic        rsp_extend_out
);

   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    extend_ff;
   logic    advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   srf_core u_core (
      .req       (req_ff),
      .extend_in (extend_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         extend_ff    <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            extend_ff    <= rsp_in.extend_out;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff.kind    <= req_kind;
         req_ff.size    <= req_size;
         req_ff.count   <= req_count;
         req_ff.operand <= req_operand;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_ff.result;
   assign rsp_flags      = rsp_ff.flags;
   assign rsp_extend_out = rsp_ff.extend_out;

endmodule

`default_nettype wire

@@ src/srf_core.sv @@
// Combinational shift/rotate datapath with N/Z/V/C and X generation.
// Depends on srf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srf_core import srf_pkg::*; (
   input  req_type     req,
   input  logic        extend_in,
   output rsp_type     rsp
);

   logic [5:0]         width_n;
   logic [4:0]         msb_idx;
   logic [31:0]        mask;
   logic [31:0]        v;
   logic [31:0]        sv;
   logic               sign;
   logic [63:0]        lsh_w;
   logic [63:0]        rsh_w;
   logic signed [63:0] ash_w;
   logic [31:0]        tmask;
   logic [31:0]        top_bits;
   logic [5:0]         rox_e;
   logic [5:0]         rox_back;
   logic [32:0]        ring;
   logic [32:0]        ring_mask;
   logic [32:0]        ring_l;
   logic [32:0]        ring_r;
   logic [5:0]         rot_e;
   logic [5:0]         rot_back;
   logic [31:0]        rot_l;
   logic [31:0]        rot_r;
   logic [31:0]        r;
   logic               cf;
   logic               vf;
   logic               x_new;
   logic               nf;
   logic               zf;
   logic               nonzero;

   always_comb begin
      case (req.size)
         SIZE_BYTE: begin
            width_n = 6'd8;
            mask    = 32'h0000_00FF;
         end
         SIZE_WORD: begin
            width_n = 6'd16;
            mask    = 32'h0000_FFFF;
         end
         default: begin
            width_n = 6'd32;
            mask    = 32'hFFFF_FFFF;
         end
      endcase
      msb_idx = 5'(width_n - 6'd1);
      v       = req.operand & mask;
      sign    = v[msb_idx];
      sv      = sign ? (v | ~mask) : v;
      nonzero = (req.count != 6'd0);

      lsh_w = {32'b0, v} << req.count;
      rsh_w = {v, 32'b0} >> req.count;
      ash_w = $signed({sv, 32'b0}) >>> req.count;

      tmask    = mask & ~(mask >> ({1'b0, req.count} + 7'd1));
      top_bits = v & tmask;

      rox_e     = srf_rox_mod(req.size, req.count);
      rox_back  = width_n + 6'd1 - rox_e;
      ring      = {1'b0, v} | ({32'b0, extend_in} << width_n);
      ring_mask = {1'b0, mask} | (33'd1 << width_n);
      ring_l    = ((ring << rox_e) | (ring >> rox_back)) & ring_mask;
      ring_r    = ((ring >> rox_e) | (ring << rox_back)) & ring_mask;

      rot_e    = req.count & (width_n - 6'd1);
      rot_back = width_n - rot_e;
      rot_l    = ((v << rot_e) | (v >> rot_back)) & mask;
      rot_r    = ((v >> rot_e) | (v << rot_back)) & mask;

      r     = v;
      cf    = 1'b0;
      vf    = 1'b0;
      x_new = extend_in;

      case (req.kind)
         KIND_ASR: begin
            if (nonzero) begin
               r     = ash_w[63:32] & mask;
               cf    = ash_w[31];
               x_new = ash_w[31];
            end
         end
         KIND_ASL, KIND_LSL: begin
            if (nonzero) begin
               r     = lsh_w[31:0] & mask;
               cf    = lsh_w[width_n];
               x_new = lsh_w[width_n];
               if (req.kind == KIND_ASL) begin
                  if (req.count >= width_n) begin
                     vf = (v != 32'd0);
                  end else begin
                     vf = (top_bits != 32'd0) && (top_bits != tmask);
                  end
               end
            end
         end
         KIND_LSR: begin
            if (nonzero) begin
               r     = rsh_w[63:32];
               cf    = rsh_w[31];
               x_new = rsh_w[31];
            end
         end
         KIND_ROXR, KIND_ROXL: begin
            if (rox_e != 6'd0) begin
               if (req.kind == KIND_ROXL) begin
                  r     = ring_l[31:0] & mask;
                  x_new = ring_l[width_n];
               end else begin
                  r     = ring_r[31:0] & mask;
                  x_new = ring_r[width_n];
               end
            end
            cf = x_new;
         end
         default: begin
            if (nonzero) begin
               if (req.kind == KIND_ROL) begin
                  r  = rot_l;
                  cf = rot_l[0];
               end else begin
                  r  = rot_r;
                  cf = rot_r[msb_idx];
               end
            end
         end
      endcase

      nf = r[msb_idx];
      zf = (r == 32'd0);
      rsp.result     = nf ? (r | ~mask) : r;
      rsp.flags      = {nf, zf, vf, cf};
      rsp.extend_out = x_new;
   end

endmodule

`default_nettype wire

@@ verif/srf_checker.sv @@
// Checker for the shift/rotate unit with flags: watches the request and result
// channels, predicts each result with its own X flag copy and compares it.
// Depends on srf_pkg.
`timescale 1ns / 1ps

module srf_checker import srf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_size,
   input  logic [5:0]  req_count,
   input  logic [31:0] req_operand,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_result,
   input  logic [3:0]  rsp_flags,
   input  logic        rsp_extend_out,
   output int          mismatches,
   output int          outstanding,
   output int          checked
);

   localparam int PRINT_CAP = 50;

   typedef struct {
      req_type request;
      rsp_type want;
   } expected_rsp_type;

   expected_rsp_type  expected_rsp_q[$];
   logic              x_flag;
   int                mismatch_total = 0;
   int                checked_total = 0;

   function automatic rsp_type shift_rotate_predict(input req_type rq, input logic x_in);
      rsp_type     o;
      logic [63:0] m;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] ring;
      logic [63:0] rm;
      logic [63:0] top;
      int          n;
      int          c;
      int          e;
      logic        sgn;
      logic        cf;
      logic        vf;
      logic        x;
      logic        nf;
      n = (rq.size == SIZE_BYTE) ? 8 : (rq.size == SIZE_WORD) ? 16 : 32;
      m = (64'd1 << n) - 64'd1;
      v = {32'd0, rq.operand} & m;
      sgn = v[n-1];
      r = v;
      cf = 1'b0;
      vf = 1'b0;
      x = x_in;
      c = rq.count;
      case (rq.kind)
         KIND_ASR: begin
            if (c != 0) begin
               if (c >= n) begin
                  r = sgn ? m : 64'd0;
                  cf = sgn;
               end else begin
                  cf = v[c-1];
                  r = v >> c;
                  if (sgn) r = r | (m & ~(m >> c));
               end
               x = cf;
            end
         end
         KIND_ASL, KIND_LSL: begin
            if (c != 0) begin
               if (c > n) begin
                  r = 64'd0;
                  cf = 1'b0;
               end else begin
                  cf = v[n-c];
                  r = (v << c) & m;
               end
               if (rq.kind == KIND_ASL) begin
                  if (c >= n) begin
                     vf = (v != 64'd0);
                  end else begin
                     top = v >> (n - 1 - c);
                     vf = (top != 64'd0) && (top != ((64'd1 << (c + 1)) - 64'd1));
                  end
               end
               x = cf;
            end
         end
         KIND_LSR: begin
            if (c != 0) begin
               if (c > n) begin
                  r = 64'd0;
                  cf = 1'b0;
               end else begin
                  cf = v[c-1];
                  r = v >> c;
               end
               x = cf;
            end
         end
         KIND_ROXR, KIND_ROXL: begin
            e = c % (n + 1);
            if (e != 0) begin
               ring = ({63'd0, x} << n) | v;
               rm = (64'd1 << (n + 1)) - 64'd1;
               if (rq.kind == KIND_ROXL) ring = ((ring << e) | (ring >> (n + 1 - e))) & rm;
               else ring = ((ring >> e) | (ring << (n + 1 - e))) & rm;
               x = ring[n];
               r = ring & m;
            end
            cf = x;
         end
         default: begin
            if (c != 0) begin
               e = c & (n - 1);
               if (e != 0) begin
                  if (rq.kind == KIND_ROL) r = ((v << e) | (v >> (n - e))) & m;
                  else r = ((v >> e) | (v << (n - e))) & m;
               end
               cf = (rq.kind == KIND_ROL) ? r[0] : r[n-1];
            end
         end
      endcase
      nf = r[n-1];
      if (nf) r = r | (64'h0000_0000_FFFF_FFFF & ~m);
      o.result = r[31:0];
      o.flags = {nf, (r == 64'd0), vf, cf};
      o.extend_out = x;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input req_type rq,
                                  input logic [31:0] got, input logic [31:0] want);
      if (mismatch_total < PRINT_CAP)
         $display("%0t ns: bad %s (kind %0d size %0d count %0d operand %h): got %h want %h",
                  $realtime, what, rq.kind, rq.size, rq.count, rq.operand, got, want);
      mismatch_total++;
   endtask

   always @(posedge clock) begin : watch
      expected_rsp_type head;
      expected_rsp_type fresh;
      if (reset) begin
         expected_rsp_q.delete();
         x_flag = 1'b0;
      end else begin
         // pop before push: a request never completes in the cycle it is taken
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_result, 32'd0);
            end else begin
               head = expected_rsp_q.pop_front();
               checked_total++;
               if (rsp_result !== head.want.result)
                  report_mismatch("result", head.request, rsp_result, head.want.result);
               if (rsp_flags !== head.want.flags)
                  report_mismatch("flags", head.request, {28'd0, rsp_flags},
                                  {28'd0, head.want.flags});
               if (rsp_extend_out !== head.want.extend_out)
                  report_mismatch("extend", head.request, {31'd0, rsp_extend_out},
                                  {31'd0, head.want.extend_out});
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            fresh.request = {req_kind, req_size, req_count, req_operand};
            fresh.want = shift_rotate_predict(fresh.request, x_flag);
            x_flag = fresh.want.extend_out;
            expected_rsp_q.push_back(fresh);
         end
      end
      mismatches <= mismatch_total;
      outstanding <= expected_rsp_q.size();
      checked <= checked_total;
   end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for shift_rotate_unit_with_flags_unit: clock, reset, request
// stimulus and result-side stall; srf_checker does the prediction and compare.
// Depends on srf_pkg, srf_checker and the unit itself.
`timescale 1ns / 1ps

module tb_top;
   import srf_pkg::*;

   localparam logic [1:0] SIZE_LONG = 2'd2;
   localparam logic [1:0] SIZE_ODD  = 2'd3;   // treated as long
   localparam int RANDOM_ITEMS = 1875;
   localparam int QUIET_TAIL   = 300;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = KIND_ASR;
   logic [1:0]  req_size = SIZE_BYTE;
   logic [5:0]  req_count = 6'd0;
   logic [31:0] req_operand = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;
   logic [3:0]  rsp_flags;
   logic        rsp_extend_out;

   int   mismatches;
   int   outstanding;
   int   checked;
   int   cycle_count = 0;
   int   sent_total = 0;
   bit   gaps_on = 1'b0;
   logic quiet = 1'b0;

   always #1 clock = ~clock;

   shift_rotate_unit_with_flags_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_size(req_size), .req_count(req_count),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result(rsp_result), .rsp_flags(rsp_flags), .rsp_extend_out(rsp_extend_out)
   );

   srf_checker shift_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_size(req_size), .req_count(req_count),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result(rsp_result), .rsp_flags(rsp_flags), .rsp_extend_out(rsp_extend_out),
      .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, outstanding);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off, none near the end
   initial begin : rsp_side
      int  rx_cycle;
      int  next_switch;
      bit  stall_on;
      bit  held;
      rx_cycle = 0;
      next_switch = 256;
      stall_on = 1'b1;
      held = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= next_switch) begin
            stall_on = ($urandom_range(0, 2) != 0);
            next_switch = rx_cycle + 256;
         end
         if (!held && rx_cycle >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rx_cycle++;
            end
         end else if (stall_on && !quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 12)) begin
               @(posedge clock);
               rx_cycle++;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic [2:0] kind, input logic [1:0] size,
                               input logic [5:0] count, input logic [31:0] operand);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_size <= size;
      req_count <= count;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_total++;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         req_kind <= 3'($urandom());
         req_size <= 2'($urandom());
         req_count <= 6'($urandom());
         req_operand <= $urandom();
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [2:0]  kind;
      logic [1:0]  size;
      logic [5:0]  count;
      logic [31:0] operand;
      int          width;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: count zero, ASR sign fill past the width, LSR carry,
      // shifts past the width, ASL overflow, ROX counts that wrap to zero
      send_request(KIND_ASL,  SIZE_BYTE, 6'd0,  32'hFFFF_FF80);
      send_request(KIND_ASR,  SIZE_BYTE, 6'd9,  32'hFFFF_FF80);
      send_request(KIND_ASR,  SIZE_LONG, 6'd40, 32'h8000_0000);
      send_request(KIND_ASR,  SIZE_WORD, 6'd16, 32'h0000_7FFF);
      send_request(KIND_ASR,  SIZE_LONG, 6'd0,  32'hFFFF_FFFF);
      send_request(KIND_LSR,  SIZE_LONG, 6'd1,  32'hFFFF_FFFF);
      send_request(KIND_LSR,  SIZE_BYTE, 6'd9,  32'hFFFF_FFFF);
      send_request(KIND_LSR,  SIZE_BYTE, 6'd8,  32'hFFFF_FF80);
      send_request(KIND_LSL,  SIZE_WORD, 6'd17, 32'hFFFF_FFFF);
      send_request(KIND_LSL,  SIZE_WORD, 6'd16, 32'h0000_0001);
      send_request(KIND_ASL,  SIZE_BYTE, 6'd1,  32'h0000_0040);
      send_request(KIND_ASL,  SIZE_BYTE, 6'd2,  32'hFFFF_FFE0);
      send_request(KIND_ASL,  SIZE_LONG, 6'd63, 32'h0000_0001);
      send_request(KIND_ASL,  SIZE_LONG, 6'd32, 32'h0000_0000);
      send_request(KIND_ROXL, SIZE_BYTE, 6'd9,  32'h0000_0055);
      send_request(KIND_ROXR, SIZE_BYTE, 6'd1,  32'h0000_0001);
      send_request(KIND_ROXR, SIZE_BYTE, 6'd1,  32'h0000_0000);
      send_request(KIND_ROXL, SIZE_LONG, 6'd33, 32'h1234_5678);
      send_request(KIND_ROXL, SIZE_LONG, 6'd63, 32'h8000_0001);
      send_request(KIND_ROXR, SIZE_WORD, 6'd17, 32'hFFFF_8001);
      send_request(KIND_ROR,  SIZE_BYTE, 6'd8,  32'hFFFF_FF81);
      send_request(KIND_ROL,  SIZE_WORD, 6'd0,  32'hFFFF_8001);
      send_request(KIND_ROL,  SIZE_LONG, 6'd63, 32'h8000_0001);
      send_request(KIND_ROR,  SIZE_LONG, 6'd1,  32'h0000_0001);
      send_request(KIND_LSL,  SIZE_ODD,  6'd4,  32'hF000_000F);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
         else if (i % 150 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (i == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
         kind = 3'($urandom_range(0, 7));
         size = ($urandom_range(0, 9) == 0) ? SIZE_ODD : 2'($urandom_range(0, 2));
         width = (size == SIZE_BYTE) ? 8 : (size == SIZE_WORD) ? 16 : 32;
         case ($urandom_range(0, 3))
            0: count = 6'($urandom_range(0, 9));
            1: count = 6'(width - 1 + int'($urandom_range(0, 2)));
            default: count = 6'($urandom_range(0, 63));
         endcase
         case ($urandom_range(0, 9))
            0: operand = 32'd0;
            1: operand = 32'hFFFF_FFFF;
            2: operand = $urandom();
            3: operand = 32'd1 << $urandom_range(0, 31);
            default: operand = $urandom();
         endcase
         if (operand != 32'hFFFF_FFFF && $urandom_range(0, 4) != 0) begin
            if (size == SIZE_BYTE) operand = {{24{operand[7]}}, operand[7:0]};
            else if (size == SIZE_WORD) operand = {{16{operand[15]}}, operand[15:0]};
         end
         send_request(kind, size, count, operand);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over all eight operations and all four size codes,",
               sent_total);
      $display("with a %0d-cycle result hold-off; %0d results compared",
               HOLD_CYCLES, checked);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/srf_pkg.sv
src/srf_core.sv
src/shift_rotate_unit_with_flags_unit.sv
verif/srf_checker.sv
verif/tb_top.sv
